// ----- design/quaternion_alu_assert.svh -----
// Assertion macros for the quaternion arithmetic unit.
`ifndef QUATERNION_ALU_ASSERT_SVH
`define QUATERNION_ALU_ASSERT_SVH
`ifndef SYNTH
`define QALU_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("quaternion_alu: same-cycle check failed");
`define QALU_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("quaternion_alu: next-cycle check failed");
`else
`define QALU_ASSERT_NOW(name, pre, post)
`define QALU_ASSERT_NEXT(name, pre, post)
`endif
`endif

// ----- design/qalu_pkg.sv -----
// Shared types, constants and helper functions of the quaternion arithmetic unit.
package qalu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QB   = 33;
  localparam int SW   = 66;
  localparam int DVW  = 65;
  localparam int RMW  = 66;
  localparam int RMR  = QB + 3;
  localparam int DW   = 32 + 2 * FRAC_BITS + 1;
  localparam int CMPW = (DW > DVW + QB) ? DW : DVW + QB;
  localparam int LAT_P = 4;
  localparam int LAT_R = QB + 1;
  localparam int LAT_D = QB + 2;
  localparam int SP = LAT_P;
  localparam int SR = SP + LAT_R;
  localparam int SD = SR + LAT_D;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_SCALE = 4'd3,
    OP_NEG   = 4'd4,
    OP_CONJ  = 4'd5,
    OP_DOT   = 4'd6,
    OP_NORM  = 4'd7,
    OP_NRMZ  = 4'd8,
    OP_INV   = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZDIV = 2'd2
  } status_e;

  typedef logic signed [31:0] fix_t;
  typedef fix_t [3:0] quat_t;

  typedef struct packed {
    logic [3:0] op;
    fix_t       a_w;
    fix_t       a_x;
    fix_t       a_y;
    fix_t       a_z;
    fix_t       b_w;
    fix_t       b_x;
    fix_t       b_y;
    fix_t       b_z;
    fix_t       scale_factor;
  } req_t;

  typedef struct packed {
    fix_t       r_w;
    fix_t       r_x;
    fix_t       r_y;
    fix_t       r_z;
    fix_t       scalar_result;
    logic [1:0] status;
  } rsp_t;

  typedef struct packed {
    fix_t val;
    logic sat;
  } comp_t;

  localparam fix_t FIX_MAX = 32'sh7FFF_FFFF;
  localparam fix_t FIX_MIN = 32'sh8000_0000;
  localparam logic signed [67:0] LIM_HI = 68'sh7FFF_FFFF;
  localparam logic signed [67:0] LIM_LO = -68'sh8000_0000;
  localparam logic signed [67:0] HALF = 68'sd1 <<< (FRAC_BITS - 1);

  // Hamilton product operand map: lane, term.
  localparam logic [1:0] MUL_A [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd2, 2'd3, 2'd1},
    '{2'd0, 2'd3, 2'd1, 2'd2}
  };
  localparam logic [1:0] MUL_B [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd3, 2'd0, 2'd2, 2'd1}
  };
  localparam logic MUL_NEG [4][4] = '{
    '{1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1}
  };

  function automatic logic signed [32:0] sx(input fix_t v);
    return {v[31], v};
  endfunction

  function automatic comp_t sat_fix(input logic signed [67:0] v);
    comp_t r;
    r.sat = 1'b0;
    r.val = v[31:0];
    if (v > LIM_HI) begin
      r.sat = 1'b1;
      r.val = FIX_MAX;
    end else if (v < LIM_LO) begin
      r.sat = 1'b1;
      r.val = FIX_MIN;
    end
    return r;
  endfunction

  function automatic comp_t sign_mag(input logic [32:0] m, input logic neg, input logic ovf);
    comp_t r;
    logic [32:0] nm;
    nm = -m;
    r.sat = 1'b0;
    r.val = m[31:0];
    if (ovf) begin
      r.sat = 1'b1;
      r.val = neg ? FIX_MIN : FIX_MAX;
    end else if (neg) begin
      if (m > 33'h0_8000_0000) begin
        r.sat = 1'b1;
        r.val = FIX_MIN;
      end else begin
        r.val = nm[31:0];
      end
    end else if (m > 33'h0_7FFF_FFFF) begin
      r.sat = 1'b1;
      r.val = FIX_MAX;
    end
    return r;
  endfunction

endpackage

// ----- design/qalu_lane.sv -----
// Per-component lane: operand selection, four products, exact sum, rounding and saturation.
module qalu_lane (
  input  logic                          clk,
  input  logic                          en,
  input  logic [1:0]                    lane_id,
  input  qalu_pkg::req_t                item,
  output logic signed [qalu_pkg::SW-1:0] psum,
  output qalu_pkg::comp_t               res
);
  import qalu_pkg::*;

  quat_t a;
  quat_t b;
  logic signed [32:0] x [4];
  fix_t               y [4];
  logic signed [32:0] simple;
  logic               use_prod;
  logic signed [64:0] prod [4];
  logic signed [32:0] simple1, simple2, simple3;
  logic               use1, use2, use3;
  logic signed [SW-1:0] pair [2];
  logic signed [SW-1:0] sum3;
  logic signed [67:0] rounded;

  assign a = {item.a_z, item.a_y, item.a_x, item.a_w};
  assign b = {item.b_z, item.b_y, item.b_x, item.b_w};
  assign rounded = (68'(sum3) + HALF) >>> FRAC_BITS;

  always_comb begin
    for (int m = 0; m < 4; m++) begin
      x[m] = '0;
      y[m] = '0;
    end
    simple = '0;
    use_prod = 1'b0;
    unique case (item.op)
      OP_ADD:  simple = sx(a[lane_id]) + sx(b[lane_id]);
      OP_SUB:  simple = sx(a[lane_id]) - sx(b[lane_id]);
      OP_NEG:  simple = -sx(a[lane_id]);
      OP_CONJ: simple = (lane_id == 2'd0) ? sx(a[lane_id]) : -sx(a[lane_id]);
      OP_MUL: begin
        use_prod = 1'b1;
        for (int m = 0; m < 4; m++) begin
          x[m] = MUL_NEG[lane_id][m] ? -sx(a[MUL_A[lane_id][m]]) : sx(a[MUL_A[lane_id][m]]);
          y[m] = b[MUL_B[lane_id][m]];
        end
      end
      OP_SCALE: begin
        use_prod = 1'b1;
        x[0] = sx(a[lane_id]);
        y[0] = item.scale_factor;
      end
      OP_DOT: begin
        use_prod = 1'b1;
        if (lane_id == 2'd0) begin
          for (int m = 0; m < 4; m++) begin
            x[m] = sx(a[m]);
            y[m] = b[m];
          end
        end
      end
      OP_NORM, OP_NRMZ, OP_INV: begin
        if (lane_id == 2'd0) begin
          for (int m = 0; m < 4; m++) begin
            x[m] = sx(a[m]);
            y[m] = a[m];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int m = 0; m < 4; m++) begin
        prod[m] <= x[m] * y[m];
      end
      simple1 <= simple;
      use1    <= use_prod;
      pair[0] <= SW'(prod[0]) + SW'(prod[1]);
      pair[1] <= SW'(prod[2]) + SW'(prod[3]);
      simple2 <= simple1;
      use2    <= use1;
      sum3    <= pair[0] + pair[1];
      simple3 <= simple2;
      use3    <= use2;
      psum    <= sum3;
      res     <= use3 ? sat_fix(rounded) : sat_fix(68'(simple3));
    end
  end

endmodule

// ----- design/qalu_sqrt.sv -----
// Pipelined rounded square root of the sum of squares, one root bit per stage.
module qalu_sqrt (
  input  logic                    clk,
  input  logic                    en,
  input  logic [qalu_pkg::SW-1:0] rad,
  output logic [qalu_pkg::QB-1:0] root,
  output logic [qalu_pkg::SW-2:0] sq_sum
);
  import qalu_pkg::*;

  logic [RMR-1:0] rem_q [QB];
  logic [QB-1:0]  rt_q  [QB];
  logic [SW-1:0]  rad_q [QB];
  logic [SW-2:0]  s_q   [QB];
  logic [RMR-1:0] rem_d [QB];
  logic [QB-1:0]  rt_d  [QB];
  logic [SW-1:0]  rad_d [QB];
  logic [SW-2:0]  s_d   [QB];

  always_comb begin
    logic [RMR-1:0] rin;
    logic [QB-1:0]  tin;
    logic [SW-1:0]  din;
    logic [SW-2:0]  sin;
    logic [RMR-1:0] cur;
    logic [RMR-1:0] trial;
    for (int i = 0; i < QB; i++) begin
      if (i == 0) begin
        rin = '0;
        tin = '0;
        din = rad;
        sin = rad[SW-2:0];
      end else begin
        rin = rem_q[i-1];
        tin = rt_q[i-1];
        din = rad_q[i-1];
        sin = s_q[i-1];
      end
      cur   = {rin[RMR-3:0], din[SW-1:SW-2]};
      trial = {1'b0, tin, 2'b01};
      if (cur >= trial) begin
        rem_d[i] = cur - trial;
        rt_d[i]  = {tin[QB-2:0], 1'b1};
      end else begin
        rem_d[i] = cur;
        rt_d[i]  = {tin[QB-2:0], 1'b0};
      end
      rad_d[i] = {din[SW-3:0], 2'b00};
      s_d[i]   = sin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QB; i++) begin
        rem_q[i] <= rem_d[i];
        rt_q[i]  <= rt_d[i];
        rad_q[i] <= rad_d[i];
        s_q[i]   <= s_d[i];
      end
      root   <= rt_q[QB-1] + QB'(rem_q[QB-1] > RMR'(rt_q[QB-1]));
      sq_sum <= s_q[QB-1];
    end
  end

endmodule

// ----- design/qalu_div.sv -----
// Per-component pipelined restoring divider for normalize and inverse.
module qalu_div (
  input  logic                     clk,
  input  logic                     en,
  input  logic [31:0]              mag,
  input  logic                     neg,
  input  logic                     inv,
  input  logic [qalu_pkg::DVW-1:0] divisor,
  output qalu_pkg::comp_t          res
);
  import qalu_pkg::*;

  logic [DW-1:0]  dvd;
  logic           ovf;
  logic [RMW-1:0] rem_q [QB+1];
  logic [QB-1:0]  lo_q  [QB+1];
  logic [QB-1:0]  q_q   [QB+1];
  logic [DVW-1:0] d_q   [QB+1];
  logic           neg_q [QB+1];
  logic           ovf_q [QB+1];
  logic [RMW-1:0] rem_d [QB+1];
  logic [QB-1:0]  lo_d  [QB+1];
  logic [QB-1:0]  q_d   [QB+1];
  logic [33:0]    mround;

  assign dvd = inv ? (DW'(mag) << (2 * FRAC_BITS + 1)) : (DW'(mag) << (FRAC_BITS + 1));
  assign ovf = CMPW'(dvd) >= (CMPW'(divisor) << QB);
  assign mround = (34'(q_q[QB]) + 34'd1) >> 1;

  always_comb begin
    logic [RMW-1:0] cur;
    rem_d[0] = RMW'(dvd >> QB);
    lo_d[0]  = dvd[QB-1:0];
    q_d[0]   = '0;
    for (int i = 1; i <= QB; i++) begin
      cur = {rem_q[i-1][RMW-2:0], lo_q[i-1][QB-1]};
      if (cur >= RMW'(d_q[i-1])) begin
        rem_d[i] = cur - RMW'(d_q[i-1]);
        q_d[i]   = {q_q[i-1][QB-2:0], 1'b1};
      end else begin
        rem_d[i] = cur;
        q_d[i]   = {q_q[i-1][QB-2:0], 1'b0};
      end
      lo_d[i] = {lo_q[i-1][QB-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= rem_d[0];
      lo_q[0]  <= lo_d[0];
      q_q[0]   <= q_d[0];
      d_q[0]   <= divisor;
      neg_q[0] <= neg;
      ovf_q[0] <= ovf;
      for (int i = 1; i <= QB; i++) begin
        rem_q[i] <= rem_d[i];
        lo_q[i]  <= lo_d[i];
        q_q[i]   <= q_d[i];
        d_q[i]   <= d_q[i-1];
        neg_q[i] <= neg_q[i-1];
        ovf_q[i] <= ovf_q[i-1];
      end
      res <= sign_mag(mround[32:0], neg_q[QB], ovf_q[QB]);
    end
  end

endmodule

// ----- design/quaternion_alu.sv -----
// Top level of the quaternion arithmetic unit: lanes, shared root, dividers and result merge.
//
//   channel | valid     | stall     | payload
//   request | req_valid | req_stall | req (qalu_pkg::req_t)
//   result  | rsp_valid | rsp_stall | rsp (qalu_pkg::rsp_t)
//
// One item is taken every cycle while no result is held; each result is presented in order.
// The pipeline is the input register, 4 lane stages, 34 root stages and 35 divider stages.
// Reset clears only the valid bits of the pipeline and the result register.
// A held result freezes the whole pipeline; the input stage still takes an item if it is empty.

`include "quaternion_alu_assert.svh"

module quaternion_alu (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  qalu_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output qalu_pkg::rsp_t rsp
);
  import qalu_pkg::*;

  typedef struct packed {
    logic [3:0]  op;
    quat_t       a;
    comp_t [3:0] pv;
    logic [QB-1:0] root;
    logic        zero;
  } meta_t;

  logic              adv;
  logic [SD:0]       v;
  req_t              item0;
  meta_t             md [1:SD];
  logic signed [SW-1:0] psum0;
  comp_t [3:0]       pres;
  logic [QB-1:0]     root_q;
  logic [SW-2:0]     s_q;
  logic              inv;
  logic [DVW-1:0]    divisor;
  logic [31:0]       mag [4];
  logic              neg [4];
  comp_t [3:0]       dres;
  rsp_t              fin;

  assign adv = !(rsp_valid && rsp_stall);
  assign req_stall = !adv && v[0];

  for (genvar j = 0; j < 4; j++) begin : g_lane
    if (j == 0) begin : g_first
      qalu_lane u_lane (
        .clk     (clk),
        .en      (adv),
        .lane_id (2'(j)),
        .item    (item0),
        .psum    (psum0),
        .res     (pres[j])
      );
    end else begin : g_other
      qalu_lane u_lane (
        .clk     (clk),
        .en      (adv),
        .lane_id (2'(j)),
        .item    (item0),
        .psum    (),
        .res     (pres[j])
      );
    end
  end

  qalu_sqrt u_sqrt (
    .clk    (clk),
    .en     (adv),
    .rad    (psum0),
    .root   (root_q),
    .sq_sum (s_q)
  );

  assign inv = md[SR].op == OP_INV;
  assign divisor = inv ? DVW'(s_q) : DVW'(root_q);

  always_comb begin
    logic [32:0] nv;
    for (int j = 0; j < 4; j++) begin
      nv = -sx(md[SR].a[j]);
      mag[j] = md[SR].a[j][31] ? nv[31:0] : md[SR].a[j];
      if (inv && j != 0) begin
        neg[j] = !md[SR].a[j][31] && (md[SR].a[j] != '0);
      end else begin
        neg[j] = md[SR].a[j][31];
      end
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_div
    qalu_div u_div (
      .clk     (clk),
      .en      (adv),
      .mag     (mag[j]),
      .neg     (neg[j]),
      .inv     (inv),
      .divisor (divisor),
      .res     (dres[j])
    );
  end

  always_comb begin
    logic sat;
    fin = '0;
    sat = 1'b0;
    fin.status = ST_OK;
    unique case (md[SD].op)
      OP_ADD, OP_SUB, OP_MUL, OP_SCALE, OP_NEG, OP_CONJ: begin
        fin.r_w = md[SD].pv[0].val;
        fin.r_x = md[SD].pv[1].val;
        fin.r_y = md[SD].pv[2].val;
        fin.r_z = md[SD].pv[3].val;
        sat = md[SD].pv[0].sat | md[SD].pv[1].sat | md[SD].pv[2].sat | md[SD].pv[3].sat;
      end
      OP_DOT: begin
        fin.scalar_result = md[SD].pv[0].val;
        sat = md[SD].pv[0].sat;
      end
      OP_NORM: begin
        if (md[SD].root > 33'h0_7FFF_FFFF) begin
          fin.scalar_result = FIX_MAX;
          sat = 1'b1;
        end else begin
          fin.scalar_result = md[SD].root[31:0];
        end
      end
      OP_NRMZ, OP_INV: begin
        if (!md[SD].zero) begin
          fin.r_w = dres[0].val;
          fin.r_x = dres[1].val;
          fin.r_y = dres[2].val;
          fin.r_z = dres[3].val;
          sat = dres[0].sat | dres[1].sat | dres[2].sat | dres[3].sat;
        end
      end
      default: ;
    endcase
    if ((md[SD].op == OP_NRMZ || md[SD].op == OP_INV) && md[SD].zero) begin
      fin.status = ST_ZDIV;
    end else if (sat) begin
      fin.status = ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (adv || !v[0]) begin
        v[0] <= req_valid;
      end
      if (adv) begin
        v[SD:1]   <= v[SD-1:0];
        rsp_valid <= v[SD];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv || !v[0]) begin
      item0 <= req;
    end
    if (adv) begin
      md[1] <= '{op: item0.op,
                 a: {item0.a_z, item0.a_y, item0.a_x, item0.a_w},
                 pv: '0, root: '0, zero: 1'b0};
      for (int k = 2; k <= SD; k++) begin
        if (k == SP + 1) begin
          md[k] <= '{op: md[k-1].op, a: md[k-1].a, pv: pres,
                     root: md[k-1].root, zero: md[k-1].zero};
        end else if (k == SR + 1) begin
          md[k] <= '{op: md[k-1].op, a: md[k-1].a, pv: md[k-1].pv,
                     root: root_q, zero: (s_q == '0)};
        end else begin
          md[k] <= md[k-1];
        end
      end
      rsp <= fin;
    end
  end

  `QALU_ASSERT_NOW(a_zdiv_zero, rsp_valid && rsp.status == ST_ZDIV, rsp.r_w == 0 && rsp.r_x == 0 && rsp.r_y == 0 && rsp.r_z == 0 && rsp.scalar_result == 0)
  `QALU_ASSERT_NOW(a_scalar_excl, rsp_valid && rsp.scalar_result != 0, rsp.r_w == 0 && rsp.r_x == 0 && rsp.r_y == 0 && rsp.r_z == 0)
  `QALU_ASSERT_NEXT(a_drain, adv && v[SD], rsp_valid)

endmodule

// ----- tb/quaternion_alu_tb.sv -----
// Self-checking testbench for the quaternion arithmetic unit, with a bit-exact result predictor.
module quaternion_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qalu_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 120;
  localparam fix_t ONE = 32'sh0001_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  rsp_t pending_results[$];
  int errors = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_count = 0;

  quaternion_alu u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic fix_t clamp(input logic signed [69:0] v, inout logic sat);
    if (v > 70'sh7FFF_FFFF) begin
      sat = 1'b1;
      return FIX_MAX;
    end
    if (v < -70'sh8000_0000) begin
      sat = 1'b1;
      return FIX_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [69:0] wide_mul(input fix_t x, input fix_t y);
    logic signed [69:0] xx;
    logic signed [69:0] yy;
    xx = x;
    yy = y;
    return xx * yy;
  endfunction

  // Rescale an exact product sum, rounding halves toward plus infinity.
  function automatic logic signed [69:0] rescale(input logic signed [69:0] v);
    return (v + (70'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic fix_t from_mag(input logic [127:0] mag, input logic neg, inout logic sat);
    if (neg) begin
      if (mag > 128'h8000_0000) begin
        sat = 1'b1;
        return FIX_MIN;
      end
      return -mag[31:0];
    end
    if (mag > 128'h7FFF_FFFF) begin
      sat = 1'b1;
      return FIX_MAX;
    end
    return mag[31:0];
  endfunction

  function automatic logic [63:0] magnitude(input fix_t v);
    longint s;
    s = v;
    return (s < 0) ? -s : s;
  endfunction

  function automatic logic [65:0] rounded_root(input logic [65:0] s);
    logic [65:0] x;
    logic [65:0] res;
    logic [65:0] bitv;
    x = s;
    res = '0;
    bitv = 66'd1 << 64;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    if (x > res) res++;
    return res;
  endfunction

  function automatic rsp_t predict_result(input req_t q);
    fix_t a[4];
    fix_t b[4];
    fix_t r[4];
    fix_t sc;
    logic sat;
    status_e st;
    logic [65:0] ssq;
    logic [65:0] root;
    logic [127:0] t;
    rsp_t res;
    a = '{q.a_w, q.a_x, q.a_y, q.a_z};
    b = '{q.b_w, q.b_x, q.b_y, q.b_z};
    r = '{default: '0};
    sc = '0;
    sat = 1'b0;
    st = ST_OK;
    ssq = '0;
    for (int i = 0; i < 4; i++) ssq += 66'(magnitude(a[i]) * magnitude(a[i]));
    case (q.op)
      OP_ADD: for (int i = 0; i < 4; i++) r[i] = clamp(70'(a[i]) + 70'(b[i]), sat);
      OP_SUB: for (int i = 0; i < 4; i++) r[i] = clamp(70'(a[i]) - 70'(b[i]), sat);
      OP_MUL: begin
        r[0] = clamp(rescale(wide_mul(a[0], b[0]) - wide_mul(a[1], b[1])
                     - wide_mul(a[2], b[2]) - wide_mul(a[3], b[3])), sat);
        r[1] = clamp(rescale(wide_mul(a[0], b[1]) + wide_mul(a[1], b[0])
                     + wide_mul(a[2], b[3]) - wide_mul(a[3], b[2])), sat);
        r[2] = clamp(rescale(wide_mul(a[0], b[2]) + wide_mul(a[2], b[0])
                     + wide_mul(a[3], b[1]) - wide_mul(a[1], b[3])), sat);
        r[3] = clamp(rescale(wide_mul(a[0], b[3]) + wide_mul(a[3], b[0])
                     + wide_mul(a[1], b[2]) - wide_mul(a[2], b[1])), sat);
      end
      OP_SCALE: for (int i = 0; i < 4; i++)
        r[i] = clamp(rescale(wide_mul(a[i], q.scale_factor)), sat);
      OP_NEG: for (int i = 0; i < 4; i++) r[i] = clamp(-70'(a[i]), sat);
      OP_CONJ: begin
        r[0] = a[0];
        for (int i = 1; i < 4; i++) r[i] = clamp(-70'(a[i]), sat);
      end
      OP_DOT: sc = clamp(rescale(wide_mul(a[0], b[0]) + wide_mul(a[1], b[1])
                         + wide_mul(a[2], b[2]) + wide_mul(a[3], b[3])), sat);
      OP_NORM: sc = from_mag(128'(rounded_root(ssq)), 1'b0, sat);
      OP_NRMZ: begin
        root = rounded_root(ssq);
        if (root == 0) begin
          st = ST_ZDIV;
        end else begin
          for (int i = 0; i < 4; i++) begin
            t = (128'(magnitude(a[i])) << (FRAC_BITS + 1)) / 128'(root);
            r[i] = from_mag((t + 1) >> 1, a[i] < 0, sat);
          end
        end
      end
      OP_INV: begin
        if (ssq == 0) begin
          st = ST_ZDIV;
        end else begin
          for (int i = 0; i < 4; i++) begin
            t = (128'(magnitude(a[i])) << (2 * FRAC_BITS + 1)) / 128'(ssq);
            r[i] = from_mag((t + 1) >> 1, (i == 0) ? (a[i] < 0) : (a[i] > 0), sat);
          end
        end
      end
      default: ;
    endcase
    if (st == ST_OK && sat) st = ST_SAT;
    res.r_w = r[0];
    res.r_x = r[1];
    res.r_y = r[2];
    res.r_z = r[3];
    res.scalar_result = sc;
    res.status = st;
    return res;
  endfunction

  function automatic req_t make_req(input logic [3:0] op, input fix_t aw, input fix_t ax,
                                    input fix_t ay, input fix_t az, input fix_t bw,
                                    input fix_t bx, input fix_t by, input fix_t bz,
                                    input fix_t k);
    req_t q;
    q.op = op;
    q.a_w = aw; q.a_x = ax; q.a_y = ay; q.a_z = az;
    q.b_w = bw; q.b_x = bx; q.b_y = by; q.b_z = bz;
    q.scale_factor = k;
    return q;
  endfunction

  task automatic send_item(input req_t q);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req <= q;
    do @(posedge clk); while (req_stall);
    pending_results.push_back(predict_result(q));
  endtask

  function automatic fix_t random_fix();
    case ($urandom_range(0, 7))
      0: return FIX_MAX;
      1: return FIX_MIN;
      2: return '0;
      3, 4: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      5: return $signed($urandom_range(0, 255)) - 32'sd128;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed_arith();
    send_item(make_req(OP_ADD, FIX_MAX, FIX_MIN, ONE, '0, FIX_MAX, FIX_MIN, -ONE, '0, '0));
    send_item(make_req(OP_SUB, FIX_MIN, FIX_MAX, ONE, -1, FIX_MAX, FIX_MIN, ONE, 1, '0));
    send_item(make_req(OP_MUL, ONE, ONE, ONE, ONE, ONE, -ONE, ONE, -ONE, '0));
    send_item(make_req(OP_MUL, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN,
                       FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, '0));
    send_item(make_req(OP_MUL, 32'sh8000, 1, 1, 1, 1, 32'sh8000, -1, 1, '0));
    send_item(make_req(OP_SCALE, FIX_MAX, FIX_MIN, 32'sh8000, -32'sh8000, '0, '0, '0, '0, 1));
    send_item(make_req(OP_SCALE, FIX_MAX, FIX_MIN, ONE, -ONE, '0, '0, '0, '0, FIX_MIN));
    send_item(make_req(OP_NEG, FIX_MIN, FIX_MAX, '0, -1, '0, '0, '0, '0, '0));
    send_item(make_req(OP_CONJ, FIX_MIN, FIX_MIN, FIX_MAX, '0, '0, '0, '0, '0, '0));
    send_item(make_req(OP_DOT, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN,
                       FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, '0));
    send_item(make_req(OP_DOT, ONE, 32'sh8000, '0, '0, ONE, 1, '0, '0, '0));
  endtask

  task automatic test_directed_roots();
    send_item(make_req(OP_NORM, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, '0, '0, '0, '0, '0));
    send_item(make_req(OP_NORM, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, '0, '0, '0, '0, '0));
    send_item(make_req(OP_NORM, 1, 1, '0, '0, '0, '0, '0, '0, '0));
    send_item(make_req(OP_NRMZ, '0, '0, '0, '0, ONE, ONE, ONE, ONE, ONE));
    send_item(make_req(OP_NRMZ, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, '0, '0, '0, '0, '0));
    send_item(make_req(OP_NRMZ, 1, -1, '0, '0, '0, '0, '0, '0, '0));
    send_item(make_req(OP_INV, '0, '0, '0, '0, ONE, ONE, ONE, ONE, ONE));
    send_item(make_req(OP_INV, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, '0, '0, '0, '0, '0));
    send_item(make_req(OP_INV, 1, '0, '0, '0, '0, '0, '0, '0, '0));
    send_item(make_req(OP_INV, -ONE, ONE, -ONE, 32'sh8000, '0, '0, '0, '0, '0));
    send_item(make_req(4'(OP_INV) + 4'd1, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
    send_item(make_req(4'hF, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, '1, '1, '1, '1, '1));
  endtask

  task automatic test_random(input int count);
    logic [3:0] op;
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(OP_INV + 1, 15))
                                         : 4'($urandom_range(OP_ADD, OP_INV));
      send_item(make_req(op, random_fix(), random_fix(), random_fix(), random_fix(),
                         random_fix(), random_fix(), random_fix(), random_fix(),
                         random_fix()));
    end
  endtask

  always @(posedge clk) begin
    if (stall_count == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_count <= $urandom_range(20, 200);
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 2) == 0);
      default: rsp_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    rsp_t exp_r;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, rsp);
      end else begin
        exp_r = pending_results.pop_front();
        check_field("r_w", exp_r.r_w, rsp.r_w);
        check_field("r_x", exp_r.r_x, rsp.r_x);
        check_field("r_y", exp_r.r_y, rsp.r_y);
        check_field("r_z", exp_r.r_z, rsp.r_z);
        check_field("scalar_result", exp_r.scalar_result, rsp.scalar_result);
        check_field("status", 32'(exp_r.status), 32'(rsp.status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_arith();
    test_directed_roots();
    test_random(750);
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+design
design/qalu_pkg.sv
design/qalu_lane.sv
design/qalu_sqrt.sv
design/qalu_div.sv
design/quaternion_alu.sv
tb/quaternion_alu_tb.sv
